/* rtl/dqe_pkg.sv */
// Shared types, constants and ring-slot arithmetic of the deque engine.
`default_nettype none

package dqe_pkg;

  // Storage geometry
  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // Fixed request and response field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned DIN_W    = 32;
  localparam int unsigned DOUT_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_ERASE      = 3'd6,
    OP_NONE       = 3'd7
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Decision on one request, taken against the current head and count
  typedef struct packed {
    logic             exec;
    status_e          status;
    logic [PTR_W-1:0] addr;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_next;
  } plan_t;

  // Ring slot of a logical index; the sum stays below twice the capacity
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [CNT_W-1:0] logical);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(logical);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

endpackage

`default_nettype wire

/* rtl/dqe_stream_if.sv */
// Request and response channel interfaces of the deque engine.
`default_nettype none

interface dqe_req_if;
  logic                         valid;
  logic                         ready;
  logic [dqe_pkg::OP_W-1:0]     opcode;
  logic [dqe_pkg::POS_W-1:0]    position;
  logic [dqe_pkg::DIN_W-1:0]    data_in;

  modport source (output valid, opcode, position, data_in, input ready);
  modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

interface dqe_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dqe_pkg::DOUT_W-1:0]    data_out;
  logic [dqe_pkg::STATUS_W-1:0]  status;
  logic [dqe_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/double_ended_queue_engine.sv */
// Top level of the deque engine: ring store, request sequencer and response register.
//
//   channel  | modport | handshake     | payload
//   ---------+---------+---------------+-------------------------------
//   req_i    | sink    | valid / ready | opcode, position, data_in
//   rsp_o    | source  | valid / ready | data_out, status, occupancy
//
// One request at a time. A push or any refused request goes from acceptance straight
// to the response state, a pop or a read through a capture state first; the store is a
// single memory with a registered read, so erase and insert take a shift read and a
// shift write state for each of the k elements shifted (up to CAPACITY - 1). The next
// request is taken in the cycle after the response loads.
// Reset clears head, count, the sequencer and the response valid; the store
// holds garbage until written. A stalled response holds in its register while
// the next request is accepted; that request then waits before loading it.
`default_nettype none

module double_ended_queue_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqe_req_if.sink   req_i,
  dqe_rsp_if.source rsp_o
);
  import dqe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAPTURE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_e;

  // Sequencer and architectural state
  state_e                state_q, state_d;
  opcode_e               op_q, op_d;
  status_e               status_q, status_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cursor_q, cursor_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] dout_q, dout_d;

  // Response register
  logic                  rsp_valid_q, rsp_valid_d;
  logic [DOUT_W-1:0]     rsp_data_q, rsp_data_d;
  status_e               rsp_status_q, rsp_status_d;
  logic [OCC_W-1:0]      rsp_occ_q, rsp_occ_d;

  // Memory port
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [PTR_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata_q;
  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];

  plan_t                 plan;
  logic                  req_fire;
  logic                  rsp_free;
  logic [CNT_W-1:0]      cursor_inc;
  logic [CNT_W-1:0]      cursor_dec;

  dqe_check u_check (
    .opcode_i   (req_i.opcode),
    .position_i (req_i.position),
    .head_i     (head_q),
    .count_i    (count_q),
    .plan_o     (plan)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign cursor_inc  = cursor_q + CNT_W'(1);
  assign cursor_dec  = cursor_q - CNT_W'(1);

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.data_out  = rsp_data_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.occupancy = rsp_occ_q;

  // Ring store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    status_d     = status_q;
    head_d       = head_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    pos_d        = pos_q;
    data_d       = data_q;
    dout_d       = dout_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_data_d   = rsp_data_q;
    rsp_status_d = rsp_status_q;
    rsp_occ_d    = rsp_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = plan.addr;
    mem_wdata    = req_i.data_in[DATA_WIDTH-1:0];
    mem_re       = 1'b0;
    mem_raddr    = plan.addr;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          // Take the request, apply pointer updates and issue the first access of an executed push, pop, read or erase
          op_d     = opcode_e'(req_i.opcode);
          status_d = plan.status;
          pos_d    = CNT_W'(req_i.position);
          data_d   = req_i.data_in[DATA_WIDTH-1:0];
          dout_d   = '0;
          head_d   = plan.head_next;
          count_d  = plan.count_next;
          cursor_d = count_q;
          state_d  = S_RESP;
          if (plan.exec) begin
            unique case (opcode_e'(req_i.opcode))
              OP_PUSH_BACK, OP_PUSH_FRONT: begin
                mem_we = 1'b1;
              end
              OP_POP_BACK, OP_POP_FRONT, OP_READ, OP_ERASE: begin
                mem_re  = 1'b1;
                state_d = S_CAPTURE;
              end
              OP_INSERT: begin
                state_d = S_SHIFT_RD;
              end
              default: begin
                state_d = S_RESP;
              end
            endcase
          end
        end
      end

      S_CAPTURE: begin
        // Hold the element read or removed before the shift reuses the port
        dout_d   = mem_rdata_q;
        cursor_d = pos_q;
        state_d  = (op_q == OP_ERASE) ? S_SHIFT_RD : S_RESP;
      end

      S_SHIFT_RD: begin
        if (op_q == OP_INSERT) begin
          if (cursor_q == pos_q) begin
            // Gap has reached the insert position: drop the new element in
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_q, pos_q);
            mem_wdata = data_q;
            count_d   = count_q + CNT_W'(1);
            state_d   = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_q, cursor_dec);
            state_d   = S_SHIFT_WR;
          end
        end else begin
          if (cursor_inc >= count_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_q, cursor_inc);
            state_d   = S_SHIFT_WR;
          end
        end
      end

      S_SHIFT_WR: begin
        // Move the fetched element one place and advance the cursor
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_q, cursor_q);
        mem_wdata = mem_rdata_q;
        cursor_d  = (op_q == OP_INSERT) ? cursor_dec : cursor_inc;
        state_d   = S_SHIFT_RD;
      end

      S_RESP: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_data_d   = DOUT_W'(dout_q);
          rsp_status_d = status_q;
          rsp_occ_d    = OCC_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    cursor_q     <= cursor_d;
    pos_q        <= pos_d;
    data_q       <= data_d;
    dout_q       <= dout_d;
    rsp_data_q   <= rsp_data_d;
    rsp_status_q <= rsp_status_d;
    rsp_occ_q    <= rsp_occ_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_WR) |-> (cursor_q <= count_q))
    else $error("shift cursor beyond stored elements");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (req_fire || state_q == S_SHIFT_RD || state_q == S_SHIFT_WR))
    else $error("store written outside a push or a shift");

  a_resp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && rsp_free) |=> (rsp_valid_q && state_q == S_IDLE))
    else $error("response not loaded on completion");
`endif

endmodule

`default_nettype wire

/* rtl/dqe_check.sv */
// Request check: status, first memory slot and new head/count of one request.
`default_nettype none

module dqe_check (
  input  logic [dqe_pkg::OP_W-1:0]  opcode_i,
  input  logic [dqe_pkg::POS_W-1:0] position_i,
  input  logic [dqe_pkg::PTR_W-1:0] head_i,
  input  logic [dqe_pkg::CNT_W-1:0] count_i,
  output dqe_pkg::plan_t            plan_o
);
  import dqe_pkg::*;

  logic             full;
  logic             empty;
  logic [CNT_W-1:0] pos_ext;
  logic [PTR_W-1:0] head_dec;

  assign full     = (count_i >= CNT_W'(CAPACITY));
  assign empty    = (count_i == '0);
  assign pos_ext  = CNT_W'(position_i);
  assign head_dec = (head_i == '0) ? PTR_W'(CAPACITY - 1) : head_i - PTR_W'(1);

  always_comb begin
    plan_o            = '0;
    plan_o.status     = ST_OK;
    plan_o.head_next  = head_i;
    plan_o.count_next = count_i;
    plan_o.addr       = head_i;
    unique case (opcode_e'(opcode_i))
      OP_PUSH_BACK: begin
        if (full) plan_o.status = ST_FULL;
        else begin
          plan_o.exec       = 1'b1;
          plan_o.addr       = slot_of(head_i, count_i);
          plan_o.count_next = count_i + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) plan_o.status = ST_FULL;
        else begin
          plan_o.exec       = 1'b1;
          plan_o.addr       = head_dec;
          plan_o.head_next  = head_dec;
          plan_o.count_next = count_i + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) plan_o.status = ST_EMPTY;
        else begin
          plan_o.exec       = 1'b1;
          plan_o.addr       = slot_of(head_i, count_i - CNT_W'(1));
          plan_o.count_next = count_i - CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) plan_o.status = ST_EMPTY;
        else begin
          plan_o.exec       = 1'b1;
          plan_o.addr       = head_i;
          plan_o.head_next  = slot_of(head_i, CNT_W'(1));
          plan_o.count_next = count_i - CNT_W'(1);
        end
      end
      OP_READ, OP_ERASE: begin
        if (empty) plan_o.status = ST_EMPTY;
        else if (pos_ext >= count_i) plan_o.status = ST_RANGE;
        else begin
          plan_o.exec = 1'b1;
          plan_o.addr = slot_of(head_i, pos_ext);
        end
      end
      OP_INSERT: begin
        if (full) plan_o.status = ST_FULL;
        else if (pos_ext > count_i) plan_o.status = ST_RANGE;
        else plan_o.exec = 1'b1;
      end
      OP_NONE: begin
        plan_o.exec = 1'b0;
      end
      default: begin
        plan_o.exec = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
